// ===== sv/ppt_pkg.sv =====
// Package: shared types and constants for the projective point transform.
`default_nettype none
package ppt_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int COEF_W     = 32;

	typedef enum logic [2:0] {
		MODE_IDENT  = 3'd0,
		MODE_TRANS  = 3'd1,
		MODE_SCALE  = 3'd2,
		MODE_SWAP   = 3'd3,
		MODE_AFFINE = 3'd4,
		MODE_PROJ   = 3'd5,
		MODE_DEGEN  = 3'd6
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 3'd0,
		REG_DIAG   = 3'd1,
		REG_CROSS  = 3'd2,
		REG_OFFSET = 3'd3,
		REG_PERSP  = 3'd4,
		REG_W_BIAS = 3'd5
	} reg_idx_t;

	localparam logic [CFG_DATA_W-1:0] DIAG_RST   = 64'h0001_0000_0001_0000;
	localparam logic [COEF_W-1:0]     W_BIAS_RST = 32'h0001_0000;

endpackage
`default_nettype wire

// ===== sv/ppt_in_if.sv =====
// Interface: input point channel.
`default_nettype none
interface ppt_in_if #(parameter int CW = 32);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] x_in;
	logic signed [CW-1:0] y_in;
	logic                 last_in;

	modport source (output valid, output x_in, output y_in, output last_in, input ready);
	modport sink   (input valid, input x_in, input y_in, input last_in, output ready);
endinterface
`default_nettype wire

// ===== sv/ppt_out_if.sv =====
// Interface: mapped point channel.
`default_nettype none
interface ppt_out_if #(parameter int CW = 32);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] x_out;
	logic signed [CW-1:0] y_out;
	logic                 clamped;
	logic                 last_out;

	modport source (output valid, output x_out, output y_out, output clamped, output last_out,
		input ready);
	modport sink   (input valid, input x_out, input y_out, input clamped, input last_out,
		output ready);
endinterface
`default_nettype wire

// ===== sv/ppt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, x and y over a shared divisor.
`default_nettype none
module ppt_div #(
	parameter int NW = 83,
	parameter int DW = 66,
	parameter int QW = 32,
	parameter int PW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num_x,
	input  wire logic [NW-1:0] num_y,
	input  wire logic [DW-1:0] den,
	input  wire logic [PW-1:0] side_in,
	output logic               out_valid,
	output logic [QW-1:0]      q_x,
	output logic [QW-1:0]      q_y,
	output logic               ovf_x,
	output logic               ovf_y,
	output logic [PW-1:0]      side_out
);

	logic          v_s    [0:QW];
	logic [DW-1:0] rem_x_s[0:QW];
	logic [DW-1:0] rem_y_s[0:QW];
	logic [QW-1:0] lo_x_s [0:QW];
	logic [QW-1:0] lo_y_s [0:QW];
	logic [QW-1:0] qx_s   [0:QW];
	logic [QW-1:0] qy_s   [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic          ovx_s  [0:QW];
	logic          ovy_s  [0:QW];
	logic [PW-1:0] side_s [0:QW];

	logic [NW-1:0] hi_x, hi_y;

	// quotient fits QW bits unless the top part already reaches the divisor
	assign hi_x = num_x >> QW;
	assign hi_y = num_y >> QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_x_s[0] <= hi_x[DW-1:0];
			rem_y_s[0] <= hi_y[DW-1:0];
			lo_x_s[0]  <= num_x[QW-1:0];
			lo_y_s[0]  <= num_y[QW-1:0];
			qx_s[0]    <= '0;
			qy_s[0]    <= '0;
			den_s[0]   <= den;
			ovx_s[0]   <= (hi_x >= NW'(den));
			ovy_s[0]   <= (hi_y >= NW'(den));
			side_s[0]  <= side_in;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [DW:0] tx, ty, dx;
		logic        gex, gey;

		assign dx  = {1'b0, den_s[i]};
		assign tx  = {rem_x_s[i], lo_x_s[i][QW-1]};
		assign ty  = {rem_y_s[i], lo_y_s[i][QW-1]};
		assign gex = (tx >= dx);
		assign gey = (ty >= dx);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_x_s[i+1] <= gex ? DW'(tx - dx) : tx[DW-1:0];
				rem_y_s[i+1] <= gey ? DW'(ty - dx) : ty[DW-1:0];
				lo_x_s[i+1]  <= lo_x_s[i] << 1;
				lo_y_s[i+1]  <= lo_y_s[i] << 1;
				qx_s[i+1]    <= {qx_s[i][QW-2:0], gex};
				qy_s[i+1]    <= {qy_s[i][QW-2:0], gey};
				den_s[i+1]   <= den_s[i];
				ovx_s[i+1]   <= ovx_s[i];
				ovy_s[i+1]   <= ovy_s[i];
				side_s[i+1]  <= side_s[i];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign q_x       = qx_s[QW];
	assign q_y       = qy_s[QW];
	assign ovf_x     = ovx_s[QW];
	assign ovf_y     = ovy_s[QW];
	assign side_out  = side_s[QW];

endmodule
`default_nettype wire

// ===== sv/projective_point_transform.sv =====
// Top level: 2D homogeneous 3x3 point transform, Q fixed point, fully pipelined.
//
//  channel  | dir | word                          | handshake
//  pt_in    | in  | x_in, y_in, last_in           | valid/ready
//  pt_out   | out | x_out, y_out, clamped, last   | valid/ready
//  cfg      | in  | cfg_index, cfg_data           | cfg_we, no wait
//
// One point per cycle while the output is not stalled; the divider
// resolves one quotient bit per stage.
// Reset clears valid bits and loads the reset matrix (identity).
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module projective_point_transform #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ppt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ppt_pkg::CFG_DATA_W-1:0]  cfg_data,
	ppt_in_if.sink                               pt_in,
	ppt_out_if.source                            pt_out
);

	localparam int CW = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int KW = ppt_pkg::COEF_W;
	localparam int PW = CW + KW;
	localparam int SW = CW + KW + 2;
	localparam int RW = SW + 1;
	localparam int NW = SW + F + 1;

	localparam logic [KW-1:0]        ONE_Q = KW'(64'd1 << F);
	localparam logic signed [RW-1:0] HALF  = RW'(1) <<< (F - 1);
	localparam logic signed [RW-1:0] MAXV  = (RW'(1) <<< (CW - 1)) - RW'(1);
	localparam logic signed [RW-1:0] MINV  = -(RW'(1) <<< (CW - 1));
	localparam logic [SW-1:0]        W_LSB = SW'(1) << (2 * F);
	localparam logic [CW-1:0]        QMAX  = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0]        QMIN  = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic          last;
		logic          proj;
		logic          zero;
		logic          sx;
		logic          sy;
		logic          eps;
		logic [CW-1:0] xo;
		logic [CW-1:0] yo;
		logic          flag;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	// configuration
	ppt_pkg::mode_t                 mode_q;
	logic [ppt_pkg::CFG_DATA_W-1:0] diag_q, cross_q, offset_q, persp_q;
	logic [KW-1:0]                  w_bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ppt_pkg::MODE_IDENT;
			diag_q   <= {ONE_Q, ONE_Q};
			cross_q  <= '0;
			offset_q <= '0;
			persp_q  <= '0;
			w_bias_q <= ONE_Q;
		end else if (cfg_we) begin
			case (cfg_index)
				ppt_pkg::REG_MODE:   mode_q   <= ppt_pkg::mode_t'(cfg_data[2:0]);
				ppt_pkg::REG_DIAG:   diag_q   <= cfg_data;
				ppt_pkg::REG_CROSS:  cross_q  <= cfg_data;
				ppt_pkg::REG_OFFSET: offset_q <= cfg_data;
				ppt_pkg::REG_PERSP:  persp_q  <= cfg_data;
				ppt_pkg::REG_W_BIAS: w_bias_q <= cfg_data[KW-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_v_q;

	assign en          = !out_v_q || pt_out.ready;
	assign pt_in.ready = en;

	// stage 1: coefficient select and products
	logic signed [KW-1:0] ca, cb, cc, cd, ce, cf;
	logic                 proj_c, zero_c;
	logic signed [CW-1:0] x_c, y_c;

	assign x_c = pt_in.x_in;
	assign y_c = pt_in.y_in;

	always_comb begin
		ca = '0; cb = '0; cc = '0; cd = '0; ce = '0; cf = '0;
		proj_c = 1'b0;
		zero_c = 1'b0;
		case (mode_q)
			ppt_pkg::MODE_IDENT: begin
				ca = ONE_Q; cd = ONE_Q;
			end
			ppt_pkg::MODE_TRANS: begin
				ca = ONE_Q; cd = ONE_Q;
				ce = offset_q[KW-1:0]; cf = offset_q[2*KW-1:KW];
			end
			ppt_pkg::MODE_SCALE: begin
				ca = diag_q[KW-1:0]; cd = diag_q[2*KW-1:KW];
				ce = offset_q[KW-1:0]; cf = offset_q[2*KW-1:KW];
			end
			ppt_pkg::MODE_SWAP: begin
				cc = cross_q[KW-1:0]; cb = cross_q[2*KW-1:KW];
				ce = offset_q[KW-1:0]; cf = offset_q[2*KW-1:KW];
			end
			ppt_pkg::MODE_AFFINE, ppt_pkg::MODE_PROJ: begin
				ca = diag_q[KW-1:0]; cd = diag_q[2*KW-1:KW];
				cc = cross_q[KW-1:0]; cb = cross_q[2*KW-1:KW];
				ce = offset_q[KW-1:0]; cf = offset_q[2*KW-1:KW];
				proj_c = (mode_q == ppt_pkg::MODE_PROJ);
			end
			default: zero_c = 1'b1;
		endcase
	end

	logic                 v_s1, v_s2, v_s3;
	logic signed [PW-1:0] p_xa_s1, p_yc_s1, p_xb_s1, p_yd_s1, p_xw_s1, p_yw_s1;
	logic signed [KW-1:0] e_s1, f_s1, g_s1;
	logic                 proj_s1, zero_s1, last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pt_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_xa_s1 <= x_c * ca;
			p_yc_s1 <= y_c * cc;
			p_xb_s1 <= x_c * cb;
			p_yd_s1 <= y_c * cd;
			p_xw_s1 <= x_c * $signed(persp_q[KW-1:0]);
			p_yw_s1 <= y_c * $signed(persp_q[2*KW-1:KW]);
			e_s1    <= ce;
			f_s1    <= cf;
			g_s1    <= w_bias_q;
			proj_s1 <= proj_c;
			zero_s1 <= zero_c;
			last_s1 <= pt_in.last_in;
		end
	end

	// stage 2: exact sums at scale 2^(2F)
	logic signed [SW-1:0] nx_s2, ny_s2, w_s2;
	logic                 proj_s2, zero_s2, last_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2   <= SW'(p_xa_s1) + SW'(p_yc_s1) + (SW'(e_s1) <<< F);
			ny_s2   <= SW'(p_xb_s1) + SW'(p_yd_s1) + (SW'(f_s1) <<< F);
			w_s2    <= SW'(p_xw_s1) + SW'(p_yw_s1) + (SW'(g_s1) <<< F);
			proj_s2 <= proj_s1;
			zero_s2 <= zero_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: rounding for plain modes, divider operands for projection
	logic signed [RW-1:0] rx, ry;
	logic [CW-1:0]        xo_c, yo_c;
	logic                 satx_c, saty_c;
	logic [SW-1:0]        mnx, mny, mw, md;
	logic                 small_w;

	assign rx = (RW'(nx_s2) + HALF) >>> F;
	assign ry = (RW'(ny_s2) + HALF) >>> F;

	always_comb begin
		satx_c = 1'b1;
		saty_c = 1'b1;
		if (rx > MAXV)      xo_c = MAXV[CW-1:0];
		else if (rx < MINV) xo_c = MINV[CW-1:0];
		else begin
			xo_c   = rx[CW-1:0];
			satx_c = 1'b0;
		end
		if (ry > MAXV)      yo_c = MAXV[CW-1:0];
		else if (ry < MINV) yo_c = MINV[CW-1:0];
		else begin
			yo_c   = ry[CW-1:0];
			saty_c = 1'b0;
		end
	end

	assign mnx     = nx_s2[SW-1] ? SW'(-nx_s2) : SW'(nx_s2);
	assign mny     = ny_s2[SW-1] ? SW'(-ny_s2) : SW'(ny_s2);
	assign mw      = w_s2[SW-1] ? SW'(-w_s2) : SW'(w_s2);
	assign small_w = (mw < W_LSB);
	// |w| under one unit (W_LSB, 1.0 at scale 2^(2F)) becomes one unit, sign kept (zero counts as positive)
	assign md      = small_w ? W_LSB : mw;

	logic [NW-1:0] numx_s3, numy_s3;
	logic [SW-1:0] den_s3;
	side_t         side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s3      <= (NW'(mnx) << F) + NW'(md >> 1);
			numy_s3      <= (NW'(mny) << F) + NW'(md >> 1);
			den_s3       <= md;
			side_s3.last <= last_s2;
			side_s3.proj <= proj_s2;
			side_s3.zero <= zero_s2;
			side_s3.sx   <= nx_s2[SW-1] ^ w_s2[SW-1];
			side_s3.sy   <= ny_s2[SW-1] ^ w_s2[SW-1];
			side_s3.eps  <= small_w;
			side_s3.xo   <= xo_c;
			side_s3.yo   <= yo_c;
			side_s3.flag <= satx_c | saty_c;
		end
	end

	logic              dv;
	logic [CW-1:0]     qx, qy;
	logic              ovx, ovy;
	logic [SIDE_W-1:0] side_raw;
	side_t             sd;

	ppt_div #(
		.NW(NW),
		.DW(SW),
		.QW(CW),
		.PW(SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.num_x    (numx_s3),
		.num_y    (numy_s3),
		.den      (den_s3),
		.side_in  (side_s3),
		.out_valid(dv),
		.q_x      (qx),
		.q_y      (qy),
		.ovf_x    (ovx),
		.ovf_y    (ovy),
		.side_out (side_raw)
	);

	assign sd = side_t'(side_raw);

	// final: sign and saturate quotients, pick result
	logic [CW-1:0] fx, fy;
	logic          fflag, px_sat, py_sat;
	logic [CW-1:0] px, py;

	always_comb begin
		px_sat = 1'b0;
		py_sat = 1'b0;
		if (!sd.sx) begin
			if (ovx || qx > QMAX) begin
				px = QMAX; px_sat = 1'b1;
			end else px = qx;
		end else begin
			if (ovx || qx > QMIN) begin
				px = QMIN; px_sat = 1'b1;
			end else px = CW'(-qx);
		end
		if (!sd.sy) begin
			if (ovy || qy > QMAX) begin
				py = QMAX; py_sat = 1'b1;
			end else py = qy;
		end else begin
			if (ovy || qy > QMIN) begin
				py = QMIN; py_sat = 1'b1;
			end else py = CW'(-qy);
		end
		if (sd.zero) begin
			fx = '0; fy = '0; fflag = 1'b0;
		end else if (sd.proj) begin
			fx = px; fy = py; fflag = sd.eps | px_sat | py_sat;
		end else begin
			fx = sd.xo; fy = sd.yo; fflag = sd.flag;
		end
	end

	logic [CW-1:0] x_out_q, y_out_q;
	logic          clamped_q, last_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out_q    <= fx;
			y_out_q    <= fy;
			clamped_q  <= fflag;
			last_out_q <= sd.last;
		end
	end

	assign pt_out.valid    = out_v_q;
	assign pt_out.x_out    = x_out_q;
	assign pt_out.y_out    = y_out_q;
	assign pt_out.clamped  = clamped_q;
	assign pt_out.last_out = last_out_q;

endmodule
`default_nettype wire

// ===== sv/ppt_check.sv =====
// Checker on the top-level ports, with its bind.
`default_nettype none
module ppt_check #(
	parameter int CW = 32
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire logic [CW-1:0] x_out,
	input wire logic [CW-1:0] y_out,
	input wire logic          clamped,
	input wire logic          last_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(x_out) && $stable(y_out) && $stable(clamped)
			&& $stable(last_out))
		else $error("output word changed while stalled");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipeline is frozen");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output stage");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind projective_point_transform ppt_check #(.CW(COORD_WIDTH)) u_ppt_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (pt_in.ready),
	.out_valid(pt_out.valid),
	.out_ready(pt_out.ready),
	.x_out    (pt_out.x_out),
	.y_out    (pt_out.y_out),
	.clamped  (pt_out.clamped),
	.last_out (pt_out.last_out)
);
`default_nettype wire
